[src/decimal_scale_align_round_macros.svh]
// ----------------------------------------------------------------------------
// decimal_scale_align_round assertion macros
// shared concurrent assertion forms, clocked on clk_i and off during reset
// ----------------------------------------------------------------------------
`ifndef DECIMAL_SCALE_ALIGN_ROUND_MACROS_SVH
`define DECIMAL_SCALE_ALIGN_ROUND_MACROS_SVH

// condition holds at every clock edge
`define DSAR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define DSAR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define DSAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dsar_pkg.sv]
// ----------------------------------------------------------------------------
// dsar_pkg
// constants and types of the decimal scale alignment block
// ----------------------------------------------------------------------------
package dsar_pkg;

  // coefficient storage width, default and port-side width
  localparam int unsigned COEF_BITS_DEF = 96;
  localparam int unsigned COEF_IO_W     = 96;
  localparam int unsigned LOW_W         = 64;
  localparam int unsigned HIGH_W        = 32;
  localparam int unsigned SCALE_W       = 5;

  // stream data widths, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 200;

  // divide-by-ten chunking: remainder (4 bits) above a 28-bit chunk fits 32 bits
  localparam int unsigned CHUNK_BITS = 28;
  localparam int unsigned REM_W      = 4;
  localparam int unsigned DIVV_W     = CHUNK_BITS + REM_W;
  localparam int unsigned PROD_W     = 2 * DIVV_W;

  // floor(v / 10) = (v * DIV_RECIP) >> DIV_SHIFT, exact for any 32-bit v
  localparam logic [DIVV_W-1:0] DIV_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned       DIV_SHIFT = 35;

  localparam logic [REM_W-1:0] DEC_TEN    = 4'd10;
  localparam logic [REM_W-1:0] ROUND_HALF = 4'd5;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

[src/decimal_scale_align_round.sv]
// ----------------------------------------------------------------------------
// decimal_scale_align_round
// aligns two decimal coefficients to a common scale, rounding half to even
// ----------------------------------------------------------------------------
// One transaction in, one out. The operand with the smaller scale is scaled up
// by ten one step per cycle while it still fits in COEF_BITS; any scale
// difference left is removed from the other operand by dividing by ten with
// round-half-even on the dropped digit. Each division walks the coefficient
// in 28-bit chunks through one 32x32 reciprocal multiplier, one chunk per
// cycle, then applies the rounding increment in a step of its own; there are
// NCHUNK = ceil(COEF_BITS / 28) chunks (4 at 96 bits). The multiply steps and
// the divisions together cover the scale difference; a multiply step that no
// longer fits hands over to division. Nothing moves when the scales are equal
// or the smaller-scale side is zero. The input is not ready from acceptance
// until the result transaction completes, and is ready again in the cycle
// after it.
`include "decimal_scale_align_round_macros.svh"

module decimal_scale_align_round #(
  parameter int unsigned COEF_BITS = dsar_pkg::COEF_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // a_coef_low, a_coef_high, a_scale, a_negative,
  // b_coef_low, b_coef_high, b_scale, b_negative, zero pad
  input  logic [dsar_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // out_a_low, out_a_high, out_b_low, out_b_high, common_scale,
  // out_a_negative, out_b_negative, zero pad
  output logic [dsar_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i
);

  localparam int unsigned NCHUNK = (COEF_BITS + dsar_pkg::CHUNK_BITS - 1) / dsar_pkg::CHUNK_BITS;
  localparam int unsigned DIV_W  = NCHUNK * dsar_pkg::CHUNK_BITS;
  localparam int unsigned IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NCHUNK - 1);

  dsar_pkg::state_e state_q, state_d;

  logic [COEF_BITS-1:0]          grow_q, grow_d;
  logic [DIV_W-1:0]              shrink_q, shrink_d;
  logic                          swap_q, swap_d;
  logic [dsar_pkg::SCALE_W-1:0]  diff_q, diff_d;
  logic [dsar_pkg::SCALE_W-1:0]  common_q, common_d;
  logic                          a_neg_q, a_neg_d;
  logic                          b_neg_q, b_neg_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic [dsar_pkg::REM_W-1:0]    rem_q, rem_d;

  // input field unpacking
  logic [dsar_pkg::LOW_W-1:0]    in_a_low, in_b_low;
  logic [dsar_pkg::HIGH_W-1:0]   in_a_high, in_b_high;
  logic [dsar_pkg::SCALE_W-1:0]  in_a_scale, in_b_scale;
  logic                          in_a_neg, in_b_neg;
  logic [COEF_BITS-1:0]          in_a_coef, in_b_coef;

  assign in_a_low   = s_axis_tdata_i[63:0];
  assign in_a_high  = s_axis_tdata_i[95:64];
  assign in_a_scale = s_axis_tdata_i[100:96];
  assign in_a_neg   = s_axis_tdata_i[101];
  assign in_b_low   = s_axis_tdata_i[165:102];
  assign in_b_high  = s_axis_tdata_i[197:166];
  assign in_b_scale = s_axis_tdata_i[202:198];
  assign in_b_neg   = s_axis_tdata_i[203];

  // coefficient bits above COEF_BITS are dropped
  assign in_a_coef = COEF_BITS'({in_a_high, in_a_low});
  assign in_b_coef = COEF_BITS'({in_b_high, in_b_low});

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // multiply by ten: 8x + 2x, fits when the top four bits stay clear
  logic [COEF_BITS+3:0] mul_p;
  logic                 mul_fits;
  assign mul_p    = {1'b0, grow_q, 3'b000} + {3'b000, grow_q, 1'b0};
  assign mul_fits = (mul_p[COEF_BITS+3:COEF_BITS] == 4'd0);

  // divide one chunk by ten through the reciprocal multiplier
  logic [dsar_pkg::CHUNK_BITS-1:0] div_chunk;
  logic [dsar_pkg::DIVV_W-1:0]     div_v;
  logic [dsar_pkg::PROD_W-1:0]     div_prod;
  logic [dsar_pkg::CHUNK_BITS-1:0] div_quo;
  logic [dsar_pkg::DIVV_W-1:0]     div_back;
  logic [dsar_pkg::REM_W-1:0]      div_rem;

  assign div_chunk = shrink_q[idx_q * dsar_pkg::CHUNK_BITS +: dsar_pkg::CHUNK_BITS];
  assign div_v     = {rem_q, div_chunk};
  assign div_prod  = dsar_pkg::PROD_W'(div_v) * dsar_pkg::PROD_W'(dsar_pkg::DIV_RECIP);
  assign div_quo   = div_prod[dsar_pkg::DIV_SHIFT +: dsar_pkg::CHUNK_BITS];
  assign div_back  = {1'b0, div_quo, 3'b000} + {3'b000, div_quo, 1'b0};
  assign div_rem   = dsar_pkg::REM_W'(div_v - div_back);

  // round half to even on the dropped digit
  logic round_up;
  assign round_up = (rem_q > dsar_pkg::ROUND_HALF) ||
                    ((rem_q == dsar_pkg::ROUND_HALF) && shrink_q[0]);

  // sequencer
  always_comb begin
    state_d  = state_q;
    grow_d   = grow_q;
    shrink_d = shrink_q;
    swap_d   = swap_q;
    diff_d   = diff_q;
    common_d = common_q;
    a_neg_d  = a_neg_q;
    b_neg_d  = b_neg_q;
    idx_d    = idx_q;
    rem_d    = rem_q;
    unique case (state_q)
      dsar_pkg::ST_IDLE: begin
        if (in_fire) begin
          a_neg_d = in_a_neg;
          b_neg_d = in_b_neg;
          idx_d   = IDX_TOP;
          rem_d   = '0;
          if (in_a_scale > in_b_scale) begin
            swap_d   = 1'b1;
            common_d = in_a_scale;
            diff_d   = in_a_scale - in_b_scale;
            grow_d   = in_b_coef;
            shrink_d = DIV_W'(in_a_coef);
          end else begin
            swap_d   = 1'b0;
            common_d = in_b_scale;
            diff_d   = in_b_scale - in_a_scale;
            grow_d   = in_a_coef;
            shrink_d = DIV_W'(in_b_coef);
          end
          if ((diff_d == '0) || (grow_d == '0)) begin
            state_d = dsar_pkg::ST_DONE;
          end else begin
            state_d = dsar_pkg::ST_MUL;
          end
        end
      end
      dsar_pkg::ST_MUL: begin
        if (mul_fits) begin
          grow_d = mul_p[COEF_BITS-1:0];
          diff_d = diff_q - 1'b1;
          if (diff_q == dsar_pkg::SCALE_W'(1)) begin
            state_d = dsar_pkg::ST_DONE;
          end
        end else begin
          state_d = dsar_pkg::ST_DIV;
        end
      end
      dsar_pkg::ST_DIV: begin
        shrink_d[idx_q * dsar_pkg::CHUNK_BITS +: dsar_pkg::CHUNK_BITS] = div_quo;
        rem_d = div_rem;
        if (idx_q == '0) begin
          state_d = dsar_pkg::ST_ROUND;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      dsar_pkg::ST_ROUND: begin
        shrink_d = shrink_q + DIV_W'(round_up);
        diff_d   = diff_q - 1'b1;
        common_d = common_q - 1'b1;
        idx_d    = IDX_TOP;
        rem_d    = '0;
        if (diff_q == dsar_pkg::SCALE_W'(1)) begin
          state_d = dsar_pkg::ST_DONE;
        end else begin
          state_d = dsar_pkg::ST_DIV;
        end
      end
      dsar_pkg::ST_DONE: begin
        if (out_fire) begin
          state_d = dsar_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dsar_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsar_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_q   <= '0;
      shrink_q <= '0;
      swap_q   <= 1'b0;
      diff_q   <= '0;
      common_q <= '0;
      a_neg_q  <= 1'b0;
      b_neg_q  <= 1'b0;
      idx_q    <= '0;
      rem_q    <= '0;
    end else begin
      grow_q   <= grow_d;
      shrink_q <= shrink_d;
      swap_q   <= swap_d;
      diff_q   <= diff_d;
      common_q <= common_d;
      a_neg_q  <= a_neg_d;
      b_neg_q  <= b_neg_d;
      idx_q    <= idx_d;
      rem_q    <= rem_d;
    end
  end

  // result packing
  logic [dsar_pkg::COEF_IO_W-1:0] out_a, out_b;
  assign out_a = swap_q ? dsar_pkg::COEF_IO_W'(shrink_q[COEF_BITS-1:0])
                        : dsar_pkg::COEF_IO_W'(grow_q);
  assign out_b = swap_q ? dsar_pkg::COEF_IO_W'(grow_q)
                        : dsar_pkg::COEF_IO_W'(shrink_q[COEF_BITS-1:0]);

  assign m_axis_tdata_o  = {1'b0, b_neg_q, a_neg_q, common_q, out_b, out_a};
  assign m_axis_tvalid_o = (state_q == dsar_pkg::ST_DONE);
  assign s_axis_tready_o = (state_q == dsar_pkg::ST_IDLE);

  // checks
  `DSAR_ASSERT_ALWAYS(a_rem_digit, rem_q < dsar_pkg::DEC_TEN, "remainder is not a decimal digit")
  `DSAR_ASSERT_ALWAYS(a_valid_ready_excl, !(m_axis_tvalid_o && s_axis_tready_o),
    "input ready while a result is pending")
  `DSAR_ASSERT_NEXT(a_mul_keeps_scale, state_q == dsar_pkg::ST_MUL, $stable(common_q),
    "common scale moved during a multiply step")
  `DSAR_ASSERT_NEXT(a_div_to_round, (state_q == dsar_pkg::ST_DIV) && (idx_q == '0),
    state_q == dsar_pkg::ST_ROUND, "last chunk not followed by rounding")
  `DSAR_ASSERT_NEXT(a_work_nonzero_diff,
    (state_q == dsar_pkg::ST_MUL) || (state_q == dsar_pkg::ST_ROUND),
    $past(diff_q) != '0, "scale step taken with no difference left")

endmodule

[tb/sv/dsar_align_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsar_align_checker
// watches both stream channels of the decimal scale aligner, predicts each
// aligned pair from the accepted operands and compares it field by field
// ----------------------------------------------------------------------------
module dsar_align_checker #(
  parameter int unsigned COEF_BITS = dsar_pkg::COEF_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // a_coef_low, a_coef_high, a_scale, a_negative,
  // b_coef_low, b_coef_high, b_scale, b_negative, zero pad
  input  logic [dsar_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  // out_a_low, out_a_high, out_b_low, out_b_high, common_scale,
  // out_a_negative, out_b_negative, zero pad
  input  logic [dsar_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  output int unsigned                      mismatch_cnt_o,
  output int unsigned                      pending_cnt_o
);

  // package constants used below
  localparam int unsigned COEF_IO_W   = dsar_pkg::COEF_IO_W;
  localparam int unsigned LOW_W       = dsar_pkg::LOW_W;
  localparam int unsigned HIGH_W      = dsar_pkg::HIGH_W;
  localparam int unsigned SCALE_W     = dsar_pkg::SCALE_W;
  localparam int unsigned REM_W       = dsar_pkg::REM_W;
  localparam int unsigned IN_TDATA_W  = dsar_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = dsar_pkg::OUT_TDATA_W;
  localparam logic [dsar_pkg::REM_W-1:0] DEC_TEN    = dsar_pkg::DEC_TEN;
  localparam logic [dsar_pkg::REM_W-1:0] ROUND_HALF = dsar_pkg::ROUND_HALF;

  // operand field offsets in the input word
  localparam int unsigned A_COEF_LSB  = 0;
  localparam int unsigned A_SCALE_LSB = A_COEF_LSB + COEF_IO_W;
  localparam int unsigned A_NEG_BIT   = A_SCALE_LSB + SCALE_W;
  localparam int unsigned B_COEF_LSB  = A_NEG_BIT + 1;
  localparam int unsigned B_SCALE_LSB = B_COEF_LSB + COEF_IO_W;
  localparam int unsigned B_NEG_BIT   = B_SCALE_LSB + SCALE_W;

  // result field offsets in the output word
  localparam int unsigned OA_LSB     = 0;
  localparam int unsigned OB_LSB     = OA_LSB + COEF_IO_W;
  localparam int unsigned OSCALE_LSB = OB_LSB + COEF_IO_W;
  localparam int unsigned OA_NEG_BIT = OSCALE_LSB + SCALE_W;
  localparam int unsigned OB_NEG_BIT = OA_NEG_BIT + 1;

  typedef struct {
    logic [COEF_IO_W-1:0] a_coef;
    logic [COEF_IO_W-1:0] b_coef;
    logic [SCALE_W-1:0]   scale;
    logic                 a_neg;
    logic                 b_neg;
  } aligned_pair_t;

  aligned_pair_t aligned_q[$];
  int unsigned   mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  // bring both operands of one transaction to their common scale
  function automatic aligned_pair_t align_operands(input logic [IN_TDATA_W-1:0] d);
    aligned_pair_t        res;
    logic [COEF_IO_W-1:0] keep_mask;
    logic [COEF_IO_W-1:0] a, b, grow, shrink, quot;
    logic [COEF_IO_W+3:0] prod;
    logic [REM_W-1:0]     digit;
    logic [SCALE_W-1:0]   sa, sb, common, steps;
    logic                 a_bigger, fits;
    keep_mask = {COEF_IO_W{1'b1}} >> (COEF_IO_W - COEF_BITS);
    a  = d[A_COEF_LSB +: COEF_IO_W] & keep_mask;
    b  = d[B_COEF_LSB +: COEF_IO_W] & keep_mask;
    sa = d[A_SCALE_LSB +: SCALE_W];
    sb = d[B_SCALE_LSB +: SCALE_W];
    a_bigger = (sa > sb);
    if (a_bigger) begin
      common = sa;
      steps  = sa - sb;
      grow   = b;
      shrink = a;
    end else begin
      common = sb;
      steps  = sb - sa;
      grow   = a;
      shrink = b;
    end
    // a zero on the small-scale side means nothing moves
    if (grow == '0) steps = '0;
    // scale up the small-scale side while the product still fits
    fits = 1'b1;
    while (steps != '0 && fits) begin
      prod = {4'b0, grow} * DEC_TEN;
      if ((prod >> COEF_BITS) != '0) begin
        fits = 1'b0;
      end else begin
        grow  = prod[COEF_IO_W-1:0];
        steps = steps - 1'b1;
      end
    end
    // drop the remaining digits from the other side, half to even on each
    while (steps != '0) begin
      quot  = shrink / DEC_TEN;
      digit = REM_W'(shrink % DEC_TEN);
      if (digit > ROUND_HALF || (digit == ROUND_HALF && quot[0])) quot = quot + 1'b1;
      shrink = quot;
      steps  = steps - 1'b1;
      common = common - 1'b1;
    end
    res.a_coef = a_bigger ? shrink : grow;
    res.b_coef = a_bigger ? grow : shrink;
    res.scale  = common;
    res.a_neg  = d[A_NEG_BIT];
    res.b_neg  = d[B_NEG_BIT];
    return res;
  endfunction

  task automatic check_field(input string what, input logic [LOW_W-1:0] want,
                             input logic [LOW_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  // record accepted operands, compare each result transaction
  always @(posedge clk_i) begin
    aligned_pair_t want;
    logic [OUT_TDATA_W-1:0] got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i)
        aligned_q.push_back(align_operands(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i;
        if (aligned_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual 0x%0h", $time, got);
          mismatch_cnt++;
        end else begin
          want = aligned_q.pop_front();
          check_field("out_a_low", want.a_coef[LOW_W-1:0], got[OA_LSB +: LOW_W]);
          check_field("out_a_high", want.a_coef[COEF_IO_W-1:LOW_W],
                      got[OA_LSB + LOW_W +: HIGH_W]);
          check_field("out_b_low", want.b_coef[LOW_W-1:0], got[OB_LSB +: LOW_W]);
          check_field("out_b_high", want.b_coef[COEF_IO_W-1:LOW_W],
                      got[OB_LSB + LOW_W +: HIGH_W]);
          check_field("common_scale", want.scale, got[OSCALE_LSB +: SCALE_W]);
          check_field("out_a_negative", want.a_neg, got[OA_NEG_BIT]);
          check_field("out_b_negative", want.b_neg, got[OB_NEG_BIT]);
        end
      end
    end
    pending_cnt_o <= aligned_q.size();
  end

endmodule

[tb/sv/decimal_scale_align_round_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_scale_align_round_tb
// drives operand pairs into the decimal scale aligner under changing
// back-pressure; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module decimal_scale_align_round_tb;

  // package constants used below
  localparam int unsigned COEF_IO_W   = dsar_pkg::COEF_IO_W;
  localparam int unsigned SCALE_W     = dsar_pkg::SCALE_W;
  localparam int unsigned IN_TDATA_W  = dsar_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = dsar_pkg::OUT_TDATA_W;
  localparam logic [dsar_pkg::REM_W-1:0] DEC_TEN    = dsar_pkg::DEC_TEN;
  localparam logic [dsar_pkg::REM_W-1:0] ROUND_HALF = dsar_pkg::ROUND_HALF;

  localparam int unsigned  RESET_CYCLES = 12;
  localparam int unsigned  CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned  DRAIN_CYCLES = 200;
  localparam int unsigned  PHASE_ITEMS  = 463;
  localparam logic [95:0]  COEF_MAX     = {COEF_IO_W{1'b1}};
  localparam logic [95:0]  TENTH_MAX    = 96'h1999_9999_9999_9999_9999_9999;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned cycle_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // clock
  always #4 clk_i = ~clk_i;

  decimal_scale_align_round DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  dsar_align_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_cnt_o   (pending_cnt)
  );

  // result side back-pressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // pack one operand pair, fields from the lowest bit up
  function automatic logic [IN_TDATA_W-1:0] pack_operands(
    input logic [95:0] a, input logic [4:0] sa, input logic an,
    input logic [95:0] b, input logic [4:0] sb, input logic bn);
    return {{(IN_TDATA_W - 2 * (COEF_IO_W + SCALE_W + 1)){1'b0}},
            bn, sb, b, an, sa, a};
  endfunction

  // coefficient of random magnitude, with zero, full scale and a trailing five
  function automatic logic [95:0] rand_coef();
    logic [95:0] v;
    int unsigned kind;
    v    = {$urandom, $urandom, $urandom};
    kind = $urandom_range(11);
    if (kind == 0) begin
      v = '0;
    end else if (kind == 1) begin
      v = COEF_MAX;
    end else begin
      v = v >> (COEF_IO_W - $urandom_range(COEF_IO_W, 1));
      if (kind >= 9) v = (v / DEC_TEN) * DEC_TEN + ROUND_HALF;
    end
    return v;
  endfunction

  // mostly legal scales, now and then above the usual range
  function automatic logic [4:0] rand_scale();
    if ($urandom_range(7) == 0) return 5'($urandom_range(31, 29));
    return 5'($urandom_range(28));
  endfunction

  // one input transaction, with idle cycles in front of it
  task automatic send_operands(input logic [IN_TDATA_W-1:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata  <= item;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic send_random_pair();
    logic [4:0] sa, sb;
    sa = rand_scale();
    sb = ($urandom_range(9) == 0) ? sa : rand_scale();
    send_operands(pack_operands(rand_coef(), sa, 1'($urandom),
                                rand_coef(), sb, 1'($urandom)));
  endtask

  // stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, equal scales, zero operands, rounding, big scales
    send_operands(pack_operands('0, 5'd0, 1'b0, '0, 5'd0, 1'b0));
    send_operands(pack_operands(COEF_MAX, 5'd28, 1'b1, COEF_MAX, 5'd28, 1'b1));
    send_operands(pack_operands('0, 5'd5, 1'b0, 96'd12345, 5'd5, 1'b1));
    send_operands(pack_operands('0, 5'd3, 1'b1, 96'd123, 5'd10, 1'b0));
    send_operands(pack_operands(96'd123, 5'd10, 1'b0, '0, 5'd3, 1'b1));
    send_operands(pack_operands(96'd9, 5'd0, 1'b0, '0, 5'd28, 1'b1));
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b0, COEF_MAX, 5'd28, 1'b0));
    send_operands(pack_operands(COEF_MAX, 5'd28, 1'b1, COEF_MAX, 5'd0, 1'b1));
    // dropped five, even and odd quotient, and digits either side of it
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b0, 96'd25, 5'd1, 1'b0));
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b0, 96'd35, 5'd1, 1'b0));
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b1, 96'd26, 5'd1, 1'b0));
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b0, 96'd24, 5'd1, 1'b1));
    // rounding carry across a 32-bit word
    send_operands(pack_operands(96'd42949672955, 5'd1, 1'b0, COEF_MAX, 5'd0, 1'b0));
    // scales above the usual range
    send_operands(pack_operands(96'd1, 5'd31, 1'b0, COEF_MAX, 5'd0, 1'b1));
    send_operands(pack_operands(COEF_MAX, 5'd0, 1'b1, 96'd7, 5'd31, 1'b0));
    send_operands(pack_operands(96'd7, 5'd0, 1'b0, 96'd1, 5'd30, 1'b0));
    // partial scale-up, then the rest by division
    send_operands(pack_operands(96'd1 << 90, 5'd0, 1'b1, 96'd7, 5'd20, 1'b1));
    // last multiply that just fits, and the first that does not
    send_operands(pack_operands(TENTH_MAX, 5'd0, 1'b0, 96'd1, 5'd1, 1'b0));
    send_operands(pack_operands(TENTH_MAX + 1'b1, 5'd0, 1'b0, 96'd16, 5'd1, 1'b0));
    send_operands(pack_operands({48{2'b10}}, 5'd17, 1'b1, {48{2'b01}}, 5'd16, 1'b0));

    // random, one back-pressure setting per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 67;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct <= 30;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_pair();
    end
    s_tvalid <= 1'b0;

    // drain outstanding results, then allow stray ones to show up
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[decimal_scale_align_round.f]
+incdir+src
src/dsar_pkg.sv
src/decimal_scale_align_round.sv
tb/sv/dsar_align_checker.sv
tb/sv/decimal_scale_align_round_tb.sv
